// ===== rtl/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants for the vertex normal accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package vna_pkg;

  // Default store depth, in vertices.
  localparam int unsigned MAX_VERTICES_DEF = 4096;

  // Fixed field widths.
  localparam int unsigned VIDX_W = 12;  // vertex index on the ports
  localparam int unsigned POS_W  = 24;  // Q16.8 coordinate
  localparam int unsigned NRM_W  = 16;  // Q2.14 normal component

  // Unit normal magnitude in Q2.14.
  localparam logic [14:0] NRM_ONE = 15'd16384;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_TRI  = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_IDX,
    ST_LOAD,
    ST_RDN,
    ST_OUT,
    ST_TRD,
    ST_TCAP,
    ST_DIFF,
    ST_CROSS,
    ST_CROSS_END,
    ST_SUM,
    ST_ABS,
    ST_NORM,
    ST_SQ,
    ST_SQ_END,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIN,
    ST_WR
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic       capture;
    logic       idx_en;
    logic       load_wr;
    logic       rdn_en;
    logic       out_load;
    logic       trd_en;
    logic       tcap_en;
    logic       diff_en;
    logic       mul_en;
    logic       sum_en;
    logic       abs_en;
    logic       norm_en;
    logic       sq_en;
    logic       sq_first;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_fin;
    logic       nrm_wr;
    logic [1:0] sel;
    logic [2:0] step;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    kind_e kind;
    logic  mag_zero;
    logic  mag_hi;
    logic  mag_lo;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/vna_ctrl.sv =====
// ----------------------------------------------------------------------------
// vna_ctrl
// Sequencer: steps each triangle through reads, cross product, normalize,
// square root, divides and write back; loads and reads take a store access.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire vna_pkg::sts_t sts_i,
  output vna_pkg::cmd_t      cmd_o
);
  import vna_pkg::*;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] k_q, k_d;
  logic [1:0] i_q, i_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      i_q     <= i_d;
    end
  end

  // Next state and counters
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    i_d     = i_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_IDX;
      end
      ST_IDX: begin
        cnt_d = '0;
        case (sts_i.kind)
          KIND_LOAD: state_d = ST_LOAD;
          KIND_TRI:  state_d = ST_TRD;
          KIND_READ: state_d = ST_RDN;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_RDN:  state_d = ST_OUT;
      ST_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_TRD:  state_d = ST_TCAP;
      ST_TCAP: begin
        if (cnt_q == 5'd2) begin
          state_d = ST_DIFF;
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = ST_TRD;
        end
      end
      ST_DIFF: begin
        cnt_d   = '0;
        state_d = ST_CROSS;
      end
      ST_CROSS: begin
        if (cnt_q == 5'd5) state_d = ST_CROSS_END;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_CROSS_END: begin
        k_d     = '0;
        state_d = ST_SUM;
      end
      ST_SUM: state_d = ST_ABS;
      ST_ABS: state_d = ST_NORM;
      ST_NORM: begin
        cnt_d = '0;
        if (sts_i.mag_zero) state_d = ST_WR;
        else if (!sts_i.mag_hi && !sts_i.mag_lo) state_d = ST_SQ;
      end
      ST_SQ: begin
        if (cnt_q == 5'd2) state_d = ST_SQ_END;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_SQ_END:    state_d = ST_SQRT_INIT;
      ST_SQRT_INIT: begin
        cnt_d   = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        i_d = '0;
        if (cnt_q == 5'd31) state_d = ST_DIV_INIT;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_DIV_INIT: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == 5'd15) state_d = ST_DIV_FIN;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_DIV_FIN: begin
        if (i_q == 2'd2) begin
          state_d = ST_WR;
        end else begin
          i_d     = i_q + 2'd1;
          state_d = ST_DIV_INIT;
        end
      end
      ST_WR: begin
        if (k_q == 2'd2) begin
          state_d = ST_IDLE;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_SUM;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_IDX:  cmd_o.idx_en = 1'b1;
      ST_LOAD: cmd_o.load_wr = 1'b1;
      ST_RDN:  cmd_o.rdn_en = 1'b1;
      ST_OUT:  cmd_o.out_load = sts_i.out_free;
      ST_TRD: begin
        cmd_o.trd_en = 1'b1;
        cmd_o.sel    = cnt_q[1:0];
      end
      ST_TCAP: begin
        cmd_o.tcap_en = 1'b1;
        cmd_o.sel     = cnt_q[1:0];
      end
      ST_DIFF: cmd_o.diff_en = 1'b1;
      ST_CROSS: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.step   = cnt_q[2:0];
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        cmd_o.sel    = k_q;
      end
      ST_ABS:  cmd_o.abs_en = 1'b1;
      ST_NORM: cmd_o.norm_en = 1'b1;
      ST_SQ: begin
        cmd_o.sq_en    = 1'b1;
        cmd_o.sq_first = (cnt_q == 5'd0);
        cmd_o.sel      = cnt_q[1:0];
      end
      ST_SQRT_INIT: cmd_o.sqrt_init = 1'b1;
      ST_SQRT:      cmd_o.sqrt_step = 1'b1;
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cmd_o.sel      = i_q;
      end
      ST_DIV: cmd_o.div_step = 1'b1;
      ST_DIV_FIN: begin
        cmd_o.div_fin = 1'b1;
        cmd_o.sel     = i_q;
      end
      ST_WR: begin
        cmd_o.nrm_wr = 1'b1;
        cmd_o.sel    = k_q;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/vna_dp.sv =====
// ----------------------------------------------------------------------------
// vna_dp
// Datapath: position and normal stores, cross product multiplier, square
// and accumulate, bit-serial square root, restoring divider, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_dp #(
  parameter int unsigned MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire vna_pkg::cmd_t               cmd_i,
  output vna_pkg::sts_t                    sts_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [vna_pkg::VIDX_W-1:0]  first_vertex_i,
  input  wire logic [vna_pkg::VIDX_W-1:0]  second_vertex_i,
  input  wire logic [vna_pkg::VIDX_W-1:0]  third_vertex_i,
  input  wire logic signed [vna_pkg::POS_W-1:0] pos_x_i,
  input  wire logic signed [vna_pkg::POS_W-1:0] pos_y_i,
  input  wire logic signed [vna_pkg::POS_W-1:0] pos_z_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [vna_pkg::VIDX_W-1:0]       normal_vertex_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_x_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_y_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_z_o
);
  import vna_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  function automatic logic [AW-1:0] slot_of(input logic [VIDX_W-1:0] v);
    logic [29:0] r;
    r = 30'(v);
    for (int k = VIDX_W - 1; k >= 0; k--) begin
      if (((30'(MAX_VERTICES) << k) <= 30'(4095)) && (r >= (30'(MAX_VERTICES) << k)))
        r = r - (30'(MAX_VERTICES) << k);
    end
    return r[AW-1:0];
  endfunction

  // Stores
  logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
  logic [3*NRM_W-1:0] nrm_mem [MAX_VERTICES];
  logic [3*POS_W-1:0] prd_q;
  logic [3*NRM_W-1:0] nrd_q;

  // Item registers
  kind_e              kind_q;
  logic [VIDX_W-1:0]  raw_q [3];
  logic [3*POS_W-1:0] pin_q;
  logic [AW-1:0]      c_q [3];

  // Triangle work registers
  logic [3*POS_W-1:0]  p_q [3];
  logic [3*NRM_W-1:0]  n_q [3];
  logic signed [24:0]  u_q [3];
  logic signed [24:0]  v_q [3];
  logic signed [49:0]  mul_q;
  logic                mv_q;
  logic [2:0]          ms_q;
  logic signed [50:0]  cp_q [3];
  logic signed [51:0]  s_q [3];
  logic [51:0]         mag_q [3];
  logic                neg_q [3];
  logic [59:0]         sqm_q;
  logic                sqv_q, sqf_q;
  logic [61:0]         sumsq_q;
  logic [63:0]         rem_q, res_q, bit_q;
  logic [32:0]         r_q;
  logic [15:0]         dn_q;
  logic [15:0]         q_q;
  logic signed [NRM_W-1:0] fresh_q [3];

  // Output register
  logic                    out_valid_q;
  logic [VIDX_W-1:0]       ov_q;
  logic signed [NRM_W-1:0] ox_q, oy_q, oz_q;

  // Combinational helpers
  logic signed [24:0] ma, mb;
  logic [29:0]        sqa;
  logic [63:0]        sq_t;
  logic [45:0]        num;
  logic [32:0]        dvs;
  logic [33:0]        r2;
  logic               ge;
  logic [14:0]        qc;
  logic               zero, hi, lo;

  always_comb begin
    case (cmd_i.step)
      3'd0:    begin ma = u_q[1]; mb = v_q[2]; end
      3'd1:    begin ma = u_q[2]; mb = v_q[1]; end
      3'd2:    begin ma = u_q[0]; mb = v_q[2]; end
      3'd3:    begin ma = u_q[2]; mb = v_q[0]; end
      3'd4:    begin ma = u_q[0]; mb = v_q[1]; end
      3'd5:    begin ma = u_q[1]; mb = v_q[0]; end
      default: begin ma = '0;     mb = '0;     end
    endcase
  end

  assign sqa  = mag_q[cmd_i.sel][29:0];
  assign sq_t = res_q + bit_q;
  assign num  = {mag_q[cmd_i.sel][29:0], 15'd0} + 46'(res_q[31:0]);
  assign dvs  = {res_q[31:0], 1'b0};
  assign r2   = {r_q, dn_q[15]};
  assign ge   = (r2 >= 34'(dvs));
  assign qc   = (q_q > 16'(NRM_ONE)) ? NRM_ONE : q_q[14:0];

  always_comb begin
    zero = 1'b1;
    hi   = 1'b0;
    lo   = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (mag_q[i] != '0) zero = 1'b0;
      if (mag_q[i][51:30] != '0) hi = 1'b1;
      if (mag_q[i][51:29] != '0) lo = 1'b0;
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.mag_zero = zero;
  assign sts_o.mag_hi   = hi;
  assign sts_o.mag_lo   = lo;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Position store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) pos_mem[c_q[0]] <= pin_q;
    if (cmd_i.trd_en) prd_q <= pos_mem[c_q[cmd_i.sel]];
  end

  // Normal store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      nrm_mem[c_q[0]] <= '0;
    end else if (cmd_i.nrm_wr) begin
      nrm_mem[c_q[cmd_i.sel]] <= zero ? '0 : {fresh_q[2], fresh_q[1], fresh_q[0]};
    end
    if (cmd_i.rdn_en) begin
      nrd_q <= nrm_mem[c_q[0]];
    end else if (cmd_i.trd_en) begin
      nrd_q <= nrm_mem[c_q[cmd_i.sel]];
    end
  end

  // Item capture and index reduction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_e'(kind_i);
      raw_q[0] <= first_vertex_i;
      raw_q[1] <= second_vertex_i;
      raw_q[2] <= third_vertex_i;
      pin_q    <= {pos_z_i, pos_y_i, pos_x_i};
    end
    if (cmd_i.idx_en) begin
      for (int i = 0; i < 3; i++) c_q[i] <= slot_of(raw_q[i]);
    end
    if (cmd_i.tcap_en) begin
      p_q[cmd_i.sel] <= prd_q;
      n_q[cmd_i.sel] <= nrd_q;
    end
  end

  // Edge vectors and cross product
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= 25'($signed(p_q[1][POS_W*i +: POS_W]))
                - 25'($signed(p_q[0][POS_W*i +: POS_W]));
        v_q[i] <= 25'($signed(p_q[2][POS_W*i +: POS_W]))
                - 25'($signed(p_q[0][POS_W*i +: POS_W]));
      end
    end
    mul_q <= ma * mb;
    ms_q  <= cmd_i.step;
    if (mv_q) begin
      if (!ms_q[0]) cp_q[ms_q[2:1]] <= 51'(mul_q);
      else cp_q[ms_q[2:1]] <= cp_q[ms_q[2:1]] - 51'(mul_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q  <= 1'b0;
      sqv_q <= 1'b0;
    end else begin
      mv_q  <= cmd_i.mul_en;
      sqv_q <= cmd_i.sq_en;
    end
  end

  // Sum, magnitude, normalize shift, squares
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      for (int i = 0; i < 3; i++) begin
        s_q[i] <= (52'($signed(n_q[cmd_i.sel][NRM_W*i +: NRM_W])) <<< 2) + 52'(cp_q[i]);
      end
    end
    if (cmd_i.abs_en) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= s_q[i][51];
        mag_q[i] <= s_q[i][51] ? $unsigned(-s_q[i]) : $unsigned(s_q[i]);
      end
    end else if (cmd_i.norm_en && !zero) begin
      for (int i = 0; i < 3; i++) begin
        if (hi) mag_q[i] <= mag_q[i] >> 1;
        else if (lo) mag_q[i] <= mag_q[i] << 1;
      end
    end
    sqm_q <= sqa * sqa;
    sqf_q <= cmd_i.sq_first;
    if (sqv_q) sumsq_q <= (sqf_q ? 62'd0 : sumsq_q) + 62'(sqm_q);
  end

  // Square root, one result bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rem_q <= 64'(sumsq_q);
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end else if (cmd_i.sqrt_step) begin
      if (rem_q >= sq_t) begin
        rem_q <= rem_q - sq_t;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Restoring divide, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      r_q  <= 33'(num[45:16]);
      dn_q <= num[15:0];
      q_q  <= '0;
    end else if (cmd_i.div_step) begin
      r_q  <= ge ? 33'(r2 - 34'(dvs)) : r2[32:0];
      dn_q <= dn_q << 1;
      q_q  <= {q_q[14:0], ge};
    end
    if (cmd_i.div_fin) begin
      fresh_q[cmd_i.sel] <= neg_q[cmd_i.sel] ? -$signed(16'(qc)) : $signed(16'(qc));
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ov_q <= raw_q[0];
      ox_q <= $signed(nrd_q[NRM_W*0 +: NRM_W]);
      oy_q <= $signed(nrd_q[NRM_W*1 +: NRM_W]);
      oz_q <= $signed(nrd_q[NRM_W*2 +: NRM_W]);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign normal_vertex_o = ov_q;
  assign normal_x_o      = ox_q;
  assign normal_y_o      = oy_q;
  assign normal_z_o      = oz_q;

endmodule

`default_nettype wire

// ===== rtl/vertex_normal_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top
// Smooth vertex normals: accumulates triangle cross products per vertex.
// ----------------------------------------------------------------------------
// The block keeps a position store and a normal store, each MAX_VERTICES
// deep in single-port memories; both hold garbage until written, and there
// is no clearing pass, so load a vertex before it is used. Items are taken
// one at a time. A read may wait for the output register to free up. A
// triangle is taken in, its positions and normals are read from the
// stores, and its cross product is formed on one shared 25x25 multiplier;
// then per corner come the sum and magnitudes and, for a nonzero sum, the
// one-bit-per-cycle normalize shift, the squares, the bit-serial square
// root, the three 16-step restoring divides, and the write back. A corner
// whose sum is zero skips straight to the write back. Results go out
// through a register, so load and triangle items are taken while a read
// result still waits. Vertex indices wrap modulo MAX_VERTICES.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_normal_accumulator_top #(
  parameter int unsigned MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [vna_pkg::VIDX_W-1:0]  first_vertex_i,
  input  wire logic [vna_pkg::VIDX_W-1:0]  second_vertex_i,
  input  wire logic [vna_pkg::VIDX_W-1:0]  third_vertex_i,
  input  wire logic signed [vna_pkg::POS_W-1:0] pos_x_i,
  input  wire logic signed [vna_pkg::POS_W-1:0] pos_y_i,
  input  wire logic signed [vna_pkg::POS_W-1:0] pos_z_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [vna_pkg::VIDX_W-1:0]       normal_vertex_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_x_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_y_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_z_o
);
  import vna_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: one transfer in, then walk the item through the datapath
  vna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stores, arithmetic units and the output register
  vna_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .first_vertex_i  (first_vertex_i),
    .second_vertex_i (second_vertex_i),
    .third_vertex_i  (third_vertex_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .normal_vertex_o (normal_vertex_o),
    .normal_x_o      (normal_x_o),
    .normal_y_o      (normal_y_o),
    .normal_z_o      (normal_z_o)
  );

endmodule

`default_nettype wire

// ===== rtl/vna_checker.sv =====
// ----------------------------------------------------------------------------
// vna_checker
// Port-level checks for the vertex normal accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [11:0] normal_vertex_o,
  input wire logic signed [15:0] normal_x_o,
  input wire logic signed [15:0] normal_y_o,
  input wire logic signed [15:0] normal_z_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(normal_vertex_o)
      && $stable(normal_x_o) && $stable(normal_y_o) && $stable(normal_z_o))
    else $error("stalled result dropped or changed");

  // Busy right after a transfer in.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after a transfer");

  // Components stay unit range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o >= -16'sd16384 && normal_x_o <= 16'sd16384
      && normal_y_o >= -16'sd16384 && normal_y_o <= 16'sd16384
      && normal_z_o >= -16'sd16384 && normal_z_o <= 16'sd16384)
    else $error("normal component out of range");

  // A new result only appears after a transfer in.
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o || $past(!in_ready_o))
    else $error("result without an item");

endmodule

bind vertex_normal_accumulator_top vna_checker u_vna_checker (.*);

`default_nettype wire
